// ===== design/dst_pkg.sv =====
// Shared types and constants for the decision stump trainer.
// Used by dst_ctrl, dst_datapath and decision_stump_trainer; no dependencies.
package dst_pkg;

	localparam int NFEAT     = 9;
	localparam int FEAT_W    = 16;
	localparam int THR_W     = 18;
	localparam int DIM_OUT_W = 4;
	localparam int CNT_OUT_W = 11;

	typedef logic signed [FEAT_W-1:0] feat_t;

	typedef enum logic {
		SCAN_INIT,
		SCAN_STEP
	} scan_mode_t;

	typedef struct packed {
		logic       load_train;
		logic       load_test;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       search_begin;
		logic       eval_empty;
		logic       eval_cut;
		logic       dim_commit;
		logic       emit_train;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic has_next;
		logic last_dim;
		logic n_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/dst_ctrl.sv =====
// Sequencer for the decision stump trainer: record intake and the threshold search.
// Depends on dst_pkg; drives the dst_datapath command word.
module dst_ctrl
	import dst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_kind,
	input  logic       in_last,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       in_stall,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BEGIN,
		S_SCAN_INIT,
		S_EVAL_EMPTY,
		S_SCAN_STEP,
		S_EVAL_CUT,
		S_COMMIT,
		S_FINISH
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				// a closing record needs the output register free
				in_stall = in_last && !status.out_free;
				if (in_valid && !in_stall) begin
					if (!in_kind) begin
						cmd.load_train = 1'b1;
						if (in_last)
							state_nxt = S_BEGIN;
					end else begin
						cmd.load_test = 1'b1;
					end
				end
			end
			S_BEGIN: begin
				cmd.search_begin = 1'b1;
				if (status.n_zero) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_INIT;
					state_nxt      = S_SCAN_INIT;
				end
			end
			S_SCAN_INIT: begin
				if (status.scan_done)
					state_nxt = S_EVAL_EMPTY;
			end
			S_EVAL_EMPTY: begin
				cmd.eval_empty = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_mode  = SCAN_STEP;
				state_nxt      = S_SCAN_STEP;
			end
			S_SCAN_STEP: begin
				if (status.scan_done)
					state_nxt = S_EVAL_CUT;
			end
			S_EVAL_CUT: begin
				cmd.eval_cut = 1'b1;
				if (status.has_next) begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_STEP;
					state_nxt      = S_SCAN_STEP;
				end else begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.dim_commit = 1'b1;
				if (status.last_dim) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SCAN_INIT;
					state_nxt      = S_SCAN_INIT;
				end
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.emit_train = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy    <= (state_nxt != S_IDLE);
		end
	end

endmodule

// ===== design/dst_datapath.sv =====
// Datapath of the decision stump trainer: record store, scan engine, error
// arithmetic, stump and test registers, result register. Depends on dst_pkg.
module dst_datapath
	import dst_pkg::*;
#(
	parameter int DIMENSIONS    = 9,
	parameter int MAX_SAMPLES   = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_status_t                  status,
	input  feat_t                       feat_in [NFEAT],
	input  logic                        label_in,
	input  logic                        last_in,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic                        out_kind,
	output logic [DIM_OUT_W-1:0]        out_dim,
	output logic                        out_pol,
	output logic signed [THR_W-1:0]     out_thr,
	output logic [CNT_OUT_W-1:0]        out_err,
	output logic [CNT_OUT_W-1:0]        out_cnt,
	output logic                        out_drop
);

	localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int DW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int ROW_W = DIMENSIONS * FEAT_W + 1;
	localparam logic signed [THR_W-1:0] TWO_ONE = THR_W'(2 ** (FRACTION_BITS + 1));

	// record store: label in bit 0, features above
	logic [ROW_W-1:0] mem [MAX_SAMPLES];
	logic [ROW_W-1:0] wr_row;
	logic [ROW_W-1:0] rd_row_s1;

	logic [CW-1:0] train_cnt_q;
	logic          ovf_q;

	// scan engine
	logic          scan_act_q;
	logic [AW-1:0] idx_q;
	scan_mode_t    mode_q;
	logic          vld_s1, last_s1;
	logic          idx_last;
	feat_t         x_s1;
	logic          lab_s1;

	logic [DW-1:0] d_q;
	feat_t         min_q, v_q, next_q;
	logic          hn_q;
	logic [CW-1:0] totneg_q, le_q, leneg_q;
	logic [1:0]    eq_q;

	// per-dimension and global bests
	logic [CW-1:0]            b0_err_q, b1_err_q, g_err_q;
	logic signed [THR_W-1:0]  b0_thr_q, b1_thr_q, g_thr_q;
	logic [DIM_OUT_W-1:0]     g_dim_q;
	logic                     g_pol_q, g_valid_q;

	// stump and test state
	logic [DIM_OUT_W-1:0]     st_dim_q;
	logic                     st_pol_q, st_valid_q;
	logic signed [THR_W-1:0]  st_thr_q;
	logic [CW-1:0]            test_err_q, test_cnt_q;

	always_comb begin
		wr_row = '0;
		wr_row[0] = label_in;
		for (int k = 0; k < DIMENSIONS; k++)
			wr_row[1 + k*FEAT_W +: FEAT_W] = feat_in[k];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_train && train_cnt_q != CW'(MAX_SAMPLES))
			mem[train_cnt_q[AW-1:0]] <= wr_row;
		rd_row_s1 <= mem[idx_q];
	end

	assign idx_last = (CW'(idx_q) + CW'(1)) == train_cnt_q;
	assign x_s1     = rd_row_s1[1 + d_q*FEAT_W +: FEAT_W];
	assign lab_s1   = rd_row_s1[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			idx_q      <= '0;
			mode_q     <= SCAN_INIT;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			vld_s1  <= scan_act_q;
			last_s1 <= scan_act_q && idx_last;
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				idx_q      <= '0;
				mode_q     <= cmd.scan_mode;
			end else if (scan_act_q) begin
				if (idx_last)
					scan_act_q <= 1'b0;
				else
					idx_q <= idx_q + AW'(1);
			end
		end
	end

	// error of the cut "2x <= t" for both polarities; pol -1 is n minus pol +1
	logic [CW-1:0]  p_sel, np_sel, err0, err1;
	logic [CW:0]    err0_w;
	logic signed [THR_W-1:0] two_v, sum_v, t_cut, t_empty;

	always_comb begin
		p_sel   = cmd.eval_empty ? '0 : le_q;
		np_sel  = cmd.eval_empty ? '0 : leneg_q;
		err0_w  = {1'b0, p_sel} + {1'b0, totneg_q} - {np_sel, 1'b0};
		err0    = err0_w[CW-1:0];
		err1    = train_cnt_q - err0;
		two_v   = {v_q[FEAT_W-1], v_q, 1'b0};
		sum_v   = {{2{v_q[FEAT_W-1]}}, v_q} + {{2{next_q[FEAT_W-1]}}, next_q};
		t_empty = {min_q[FEAT_W-1], min_q, 1'b0} - TWO_ONE;
		if (eq_q > 2'd1)
			t_cut = two_v;
		else if (hn_q)
			t_cut = sum_v;
		else
			t_cut = two_v + TWO_ONE;
	end

	logic [CW-1:0]           c_err;
	logic signed [THR_W-1:0] c_thr;
	logic                    c_pol, c_upd0, c_upd1;

	always_comb begin
		c_upd0 = b0_err_q < g_err_q;
		c_err  = c_upd0 ? b0_err_q : g_err_q;
		c_upd1 = b1_err_q < c_err;
		c_thr  = c_upd1 ? b1_thr_q : (c_upd0 ? b0_thr_q : g_thr_q);
		c_pol  = c_upd1 ? 1'b1 : (c_upd0 ? 1'b0 : g_pol_q);
		if (c_upd1)
			c_err = b1_err_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			if (cmd.scan_mode == SCAN_INIT) begin
				min_q    <= {1'b0, {(FEAT_W-1){1'b1}}};
				totneg_q <= '0;
			end else begin
				le_q    <= '0;
				leneg_q <= '0;
				eq_q    <= '0;
				hn_q    <= 1'b0;
				next_q  <= v_q;
			end
		end else if (vld_s1) begin
			if (mode_q == SCAN_INIT) begin
				if (x_s1 < min_q)
					min_q <= x_s1;
				totneg_q <= totneg_q + CW'(lab_s1);
			end else begin
				if (x_s1 <= v_q) begin
					le_q    <= le_q + CW'(1);
					leneg_q <= leneg_q + CW'(lab_s1);
				end
				if (x_s1 == v_q && eq_q != 2'd2)
					eq_q <= eq_q + 2'd1;
				if (x_s1 > v_q && (!hn_q || x_s1 < next_q)) begin
					next_q <= x_s1;
					hn_q   <= 1'b1;
				end
			end
		end
		if (cmd.eval_empty) begin
			v_q      <= min_q;
			b0_err_q <= err0;
			b0_thr_q <= t_empty;
			b1_err_q <= err1;
			b1_thr_q <= t_empty;
		end
		if (cmd.eval_cut) begin
			if (err0 < b0_err_q) begin
				b0_err_q <= err0;
				b0_thr_q <= t_cut;
			end
			if (err1 < b1_err_q) begin
				b1_err_q <= err1;
				b1_thr_q <= t_cut;
			end
			if (hn_q)
				v_q <= next_q;
		end
	end

	logic [DIM_OUT_W-1:0] tsel;
	feat_t                tx;
	logic signed [THR_W-1:0] tx2;
	logic                 wrong, test_full;
	logic [CW-1:0]        t_err_n, t_cnt_n;
	logic                 ovf_n;

	always_comb begin
		tsel      = st_dim_q - DIM_OUT_W'(1);
		tx        = feat_in[tsel];
		tx2       = {tx[FEAT_W-1], tx, 1'b0};
		wrong     = st_valid_q ? (((tx2 <= st_thr_q) ^ st_pol_q) != label_in) : 1'b1;
		test_full = test_cnt_q == CW'(MAX_SAMPLES);
		t_err_n   = test_err_q + CW'(!test_full && wrong);
		t_cnt_n   = test_cnt_q + CW'(!test_full);
		ovf_n     = ovf_q || test_full;
	end

	assign status.scan_done = last_s1;
	assign status.has_next  = hn_q;
	assign status.last_dim  = d_q == DW'(DIMENSIONS - 1);
	assign status.n_zero    = train_cnt_q == '0;
	assign status.out_free  = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_cnt_q <= '0;
			ovf_q       <= 1'b0;
			d_q         <= '0;
			g_err_q     <= '0;
			g_thr_q     <= '0;
			g_dim_q     <= '0;
			g_pol_q     <= 1'b0;
			g_valid_q   <= 1'b0;
			st_dim_q    <= '0;
			st_pol_q    <= 1'b0;
			st_thr_q    <= '0;
			st_valid_q  <= 1'b0;
			test_err_q  <= '0;
			test_cnt_q  <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.emit_train || (cmd.load_test && last_in))
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			if (cmd.load_train) begin
				if (train_cnt_q != CW'(MAX_SAMPLES))
					train_cnt_q <= train_cnt_q + CW'(1);
				else
					ovf_q <= 1'b1;
			end
			if (cmd.load_test) begin
				if (last_in) begin
					test_err_q <= '0;
					test_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end else begin
					test_err_q <= t_err_n;
					test_cnt_q <= t_cnt_n;
					ovf_q      <= ovf_n;
				end
			end
			if (cmd.search_begin) begin
				d_q       <= '0;
				g_err_q   <= train_cnt_q;
				g_thr_q   <= '0;
				g_dim_q   <= '0;
				g_pol_q   <= 1'b0;
				g_valid_q <= 1'b0;
			end
			if (cmd.dim_commit) begin
				if (c_upd0 || c_upd1) begin
					g_err_q   <= c_err;
					g_thr_q   <= c_thr;
					g_pol_q   <= c_pol;
					g_dim_q   <= DIM_OUT_W'(d_q) + DIM_OUT_W'(1);
					g_valid_q <= 1'b1;
				end
				if (!status.last_dim)
					d_q <= d_q + DW'(1);
			end
			if (cmd.emit_train) begin
				st_dim_q    <= g_dim_q;
				st_pol_q    <= g_pol_q;
				st_thr_q    <= g_thr_q;
				st_valid_q  <= g_valid_q;
				train_cnt_q <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_test && last_in) begin
			out_kind <= 1'b1;
			out_dim  <= st_valid_q ? st_dim_q : '0;
			out_pol  <= st_valid_q ? st_pol_q : 1'b0;
			out_thr  <= st_valid_q ? st_thr_q : '0;
			out_err  <= CNT_OUT_W'(t_err_n);
			out_cnt  <= CNT_OUT_W'(t_cnt_n);
			out_drop <= ovf_n;
		end
		if (cmd.emit_train) begin
			out_kind <= 1'b0;
			out_dim  <= g_valid_q ? g_dim_q : '0;
			out_pol  <= g_valid_q ? g_pol_q : 1'b0;
			out_thr  <= g_valid_q ? g_thr_q : '0;
			out_err  <= g_valid_q ? CNT_OUT_W'(g_err_q) : '0;
			out_cnt  <= CNT_OUT_W'(train_cnt_q);
			out_drop <= ovf_q;
		end
	end

endmodule

// ===== design/decision_stump_trainer.sv =====
// Decision stump trainer, top level: dst_ctrl sequencer plus dst_datapath.
// Depends on dst_pkg, dst_ctrl and dst_datapath.
//
// Input channel (in_valid / in_stall) carries one record per word: kind, nine
// signed Q7.8 features, label and last_of_set. Training records (kind 0) are
// stored, one per cycle. The last training record starts the search; in_stall
// stays high until the training result is loaded into the output register.
// Each dimension takes one pass over the store for the minimum, then one pass
// per distinct value of that feature (one read a cycle). out_valid rises once
// the search has covered every dimension and the output register is free.
// Test records (kind 1) are scored in the cycle they are accepted, one per
// cycle; the last one loads the test result, valid on the next cycle.
// Output channel (out_valid / out_stall) holds one result word in a register;
// while it is stalled, records keep loading, and only a record that closes a
// set waits. Reset clears all counts, the stump and any pending result; the
// record store is not cleared, since only written entries are read.
module decision_stump_trainer
	import dst_pkg::*;
#(
	parameter int DIMENSIONS    = 9,
	parameter int MAX_SAMPLES   = 1024,
	parameter int FRACTION_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic signed [15:0]      feature_1,
	input  logic signed [15:0]      feature_2,
	input  logic signed [15:0]      feature_3,
	input  logic signed [15:0]      feature_4,
	input  logic signed [15:0]      feature_5,
	input  logic signed [15:0]      feature_6,
	input  logic signed [15:0]      feature_7,
	input  logic signed [15:0]      feature_8,
	input  logic signed [15:0]      feature_9,
	input  logic                    label_negative,
	input  logic                    last_of_set,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    summary_kind,
	output logic [3:0]              best_dimension,
	output logic                    polarity_negative,
	output logic signed [17:0]      threshold_doubled,
	output logic [10:0]             error_count,
	output logic [10:0]             sample_count,
	output logic                    dropped_flag
);

	dp_cmd_t    cmd;
	dp_status_t status;
	feat_t      feat_in [NFEAT];
	logic       busy;

	assign feat_in[0] = feature_1;
	assign feat_in[1] = feature_2;
	assign feat_in[2] = feature_3;
	assign feat_in[3] = feature_4;
	assign feat_in[4] = feature_5;
	assign feat_in[5] = feature_6;
	assign feat_in[6] = feature_7;
	assign feat_in[7] = feature_8;
	assign feat_in[8] = feature_9;

	dst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind),
		.in_last  (last_of_set),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall),
		.busy     (busy)
	);

	dst_datapath #(
		.DIMENSIONS    (DIMENSIONS),
		.MAX_SAMPLES   (MAX_SAMPLES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.feat_in   (feat_in),
		.label_in  (label_negative),
		.last_in   (last_of_set),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_kind  (summary_kind),
		.out_dim   (best_dimension),
		.out_pol   (polarity_negative),
		.out_thr   (threshold_doubled),
		.out_err   (error_count),
		.out_cnt   (sample_count),
		.out_drop  (dropped_flag)
	);

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("record accepted during search");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error_count)
			&& $stable(summary_kind))
		else $error("stalled result changed");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_dimension <= 4'(DIMENSIONS))
		else $error("dimension out of range");

	a_err_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_SAMPLES > 1024) || (error_count <= sample_count))
		else $error("more errors than records");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for decision_stump_trainer: drives records, predicts every
// result word with its own stump search and scoring model, and compares field by field.
// Depends on dst_pkg and the decision_stump_trainer RTL.
module testbench
	import dst_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int ONE_DOUBLED = 512;
	localparam bit KIND_TRAIN  = 1'b0;
	localparam bit KIND_TEST   = 1'b1;

	typedef struct {
		bit                 kind;
		logic signed [15:0] feat [NFEAT];
		bit                 neg;
		bit                 last;
	} record_t;

	typedef struct {
		bit                 kind;
		bit [3:0]           dim;
		bit                 pol;
		logic signed [17:0] thr;
		bit [10:0]          errs;
		bit [10:0]          cnt;
		bit                 drop;
	} summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic signed [15:0] feat_drv [NFEAT];
	logic label_negative = 1'b0;
	logic last_of_set = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic summary_kind;
	logic [3:0] best_dimension;
	logic polarity_negative;
	logic signed [17:0] threshold_doubled;
	logic [10:0] error_count;
	logic [10:0] sample_count;
	logic dropped_flag;

	// model state
	int  stored_feat [STORE_DEPTH][NFEAT];
	bit  stored_neg [STORE_DEPTH];
	int  n_train, n_test, test_errs;
	bit  stump_ok, overflow_pending;
	int  stump_dim, stump_pol, stump_thr;
	int  col_val [STORE_DEPTH];
	bit  col_neg [STORE_DEPTH];
	int  neg_sum [STORE_DEPTH + 1];

	summary_t expected_q[$];
	int  fail_count = 0;
	int  cycle_count = 0;
	int  items_sent = 0;
	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;
	int  stall_left = 0;

	always #5 clk = ~clk;

	decision_stump_trainer DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind),
		.feature_1(feat_drv[0]), .feature_2(feat_drv[1]), .feature_3(feat_drv[2]),
		.feature_4(feat_drv[3]), .feature_5(feat_drv[4]), .feature_6(feat_drv[5]),
		.feature_7(feat_drv[6]), .feature_8(feat_drv[7]), .feature_9(feat_drv[8]),
		.label_negative(label_negative), .last_of_set(last_of_set),
		.out_valid(out_valid), .out_stall(out_stall),
		.summary_kind(summary_kind), .best_dimension(best_dimension),
		.polarity_negative(polarity_negative), .threshold_doubled(threshold_doubled),
		.error_count(error_count), .sample_count(sample_count),
		.dropped_flag(dropped_flag)
	);

	initial begin
		foreach (feat_drv[i]) feat_drv[i] = '0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench failed");
			$finish;
		end
	end

	task automatic report(input string what);
		fail_count++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic void queue_expect(input summary_t s);
		expected_q = {expected_q, s};
	endfunction

	// Sort one dimension of the stored set and build the running count of negatives.
	function automatic void sort_column(input int d, input int n);
		int x, k;
		bit l;
		for (int i = 0; i < n; i++) begin
			x = stored_feat[i][d];
			l = stored_neg[i];
			k = i;
			while (k > 0 && col_val[k-1] > x) begin
				col_val[k] = col_val[k-1];
				col_neg[k] = col_neg[k-1];
				k--;
			end
			col_val[k] = x;
			col_neg[k] = l;
		end
		neg_sum[0] = 0;
		for (int i = 0; i < n; i++) neg_sum[i+1] = neg_sum[i] + col_neg[i];
	endfunction

	function automatic int fit_stump(input int n);
		int best, totneg, p, t, np, err;
		best = n;
		stump_ok = 1'b0;
		stump_dim = 0;
		stump_pol = 0;
		stump_thr = 0;
		for (int d = 0; d < NFEAT; d++) begin
			if (n == 0) break;
			sort_column(d, n);
			totneg = neg_sum[n];
			for (int pol = 0; pol < 2; pol++) begin
				p = 0;
				for (int j = 0; j <= n; j++) begin
					if (j == 0) t = 2 * col_val[0] - ONE_DOUBLED;
					else if (j == n) t = 2 * col_val[n-1] + ONE_DOUBLED;
					else t = col_val[j-1] + col_val[j];
					while (p < n && 2 * col_val[p] <= t) p++;
					np = neg_sum[p];
					if (pol == 0) err = (p - np) + (totneg - np);
					else err = np + ((n - p) - (totneg - np));
					if (err < best) begin
						best = err;
						stump_ok = 1'b1;
						stump_dim = d + 1;
						stump_pol = pol;
						stump_thr = t;
					end
				end
			end
		end
		return best;
	endfunction

	function automatic summary_t make_summary(input bit k, input int errs, input int cnt);
		summary_t s;
		s.kind = k;
		s.dim  = stump_ok ? stump_dim[3:0] : 4'd0;
		s.pol  = stump_ok ? stump_pol[0] : 1'b0;
		s.thr  = stump_ok ? stump_thr[17:0] : 18'sd0;
		s.errs = errs[10:0];
		s.cnt  = cnt[10:0];
		s.drop = overflow_pending;
		overflow_pending = 1'b0;
		return s;
	endfunction

	function automatic void predict_record(input record_t r);
		int errs, x;
		bit wrong, below, pred_neg;
		if (r.kind == KIND_TRAIN) begin
			if (n_train < STORE_DEPTH) begin
				for (int d = 0; d < NFEAT; d++) stored_feat[n_train][d] = r.feat[d];
				stored_neg[n_train] = r.neg;
				n_train++;
			end else begin
				overflow_pending = 1'b1;
			end
			if (r.last) begin
				errs = fit_stump(n_train);
				queue_expect(make_summary(KIND_TRAIN, errs, n_train));
				n_train = 0;
			end
		end else begin
			if (n_test < STORE_DEPTH) begin
				wrong = 1'b1;
				if (stump_ok) begin
					x = r.feat[stump_dim-1];
					below = (2 * x) <= stump_thr;
					pred_neg = below ? (stump_pol == 0) : (stump_pol != 0);
					wrong = pred_neg != r.neg;
				end
				if (wrong) test_errs++;
				n_test++;
			end else begin
				overflow_pending = 1'b1;
			end
			if (r.last) begin
				queue_expect(make_summary(KIND_TEST, test_errs, n_test));
				test_errs = 0;
				n_test = 0;
			end
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_record(input record_t r);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= r.kind;
		for (int d = 0; d < NFEAT; d++) feat_drv[d] <= r.feat[d];
		label_negative <= r.neg;
		last_of_set <= r.last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_record(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		end_burst();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_value(input int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 6)) - 3) <<< 8;
			2: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
			default: return 16'($signed($urandom_range(0, 255)) - 128);
		endcase
	endfunction

	function automatic record_t random_record(input bit k, input bit last, input int style,
						  input int key_dim, input int cut);
		record_t r;
		r.kind = k;
		r.last = last;
		for (int d = 0; d < NFEAT; d++) r.feat[d] = pick_value(style);
		// label mostly follows one dimension so the stump has something to find
		r.neg = (r.feat[key_dim] <= cut);
		if ($urandom_range(0, 4) == 0) r.neg = ~r.neg;
		return r;
	endfunction

	task automatic send_set(input bit k, input int n, input int style,
				input int key_dim, input int cut);
		for (int i = 0; i < n; i++)
			send_record(random_record(k, i == n - 1, style, key_dim, cut));
	endtask

	task automatic test_directed();
		record_t r;
		// scoring with no stump: every record is wrong
		send_set(KIND_TEST, 3, 0, 0, 0);
		// extremes in every dimension, both labels
		r.kind = KIND_TRAIN;
		r.last = 1'b0;
		for (int i = 0; i < 4; i++) begin
			for (int d = 0; d < NFEAT; d++) r.feat[d] = (i[0] ^ d[0]) ? 16'sh7fff : -16'sh8000;
			r.neg = i[1];
			r.last = (i == 3);
			send_record(r);
		end
		send_set(KIND_TEST, 4, 2, 3, 0);
		// single record training set
		send_set(KIND_TRAIN, 1, 0, 1, 0);
		send_set(KIND_TEST, 2, 0, 1, 0);
		// identical values: every threshold ties
		for (int d = 0; d < NFEAT; d++) r.feat[d] = 16'sh0100;
		r.last = 1'b0;
		for (int i = 0; i < 3; i++) begin
			r.neg = (i == 1);
			r.last = (i == 2);
			send_record(r);
		end
		send_set(KIND_TEST, 3, 1, 2, 0);
		wait_drained();
	endtask

	task automatic test_random(input int goal);
		int stop_at, style, key, cut;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			style = $urandom_range(0, 3);
			key = $urandom_range(0, NFEAT - 1);
			cut = $urandom_range(0, 1) ? 0 : int'(pick_value(style));
			if ($urandom_range(0, 3) != 0)
				send_set(KIND_TRAIN, $urandom_range(1, 20), style, key, cut);
			send_set(KIND_TEST, $urandom_range(1, 30), style, key, cut);
			if ($urandom_range(0, 7) == 0) wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_train_overflow();
		// few distinct values keep the full-store search short
		send_set(KIND_TRAIN, STORE_DEPTH + 2, 1, 4, 0);
		send_set(KIND_TEST, 10, 1, 4, 0);
		wait_drained();
	endtask

	task automatic test_output_holdoff();
		send_set(KIND_TRAIN, 6, 0, 2, 0);
		wait_drained();
		// hold the result register full while test sets keep coming
		hold_req = 1'b1;
		send_set(KIND_TEST, 5, 0, 2, 0);
		send_set(KIND_TEST, 4, 0, 2, 0);
		send_set(KIND_TEST, 6, 0, 2, 0);
		wait_drained();
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = 400;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result word against the oldest expectation
	always @(posedge clk) begin
		summary_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				e = expected_q.pop_front();
				if (summary_kind !== e.kind)
					report($sformatf("summary_kind %b exp %b", summary_kind, e.kind));
				if (best_dimension !== e.dim)
					report($sformatf("best_dimension %0d exp %0d", best_dimension, e.dim));
				if (polarity_negative !== e.pol)
					report($sformatf("polarity_negative %b exp %b",
						polarity_negative, e.pol));
				if (threshold_doubled !== e.thr)
					report($sformatf("threshold_doubled %0d exp %0d",
						threshold_doubled, e.thr));
				if (error_count !== e.errs)
					report($sformatf("error_count %0d exp %0d", error_count, e.errs));
				if (sample_count !== e.cnt)
					report($sformatf("sample_count %0d exp %0d", sample_count, e.cnt));
				if (dropped_flag !== e.drop)
					report($sformatf("dropped_flag %b exp %b", dropped_flag, e.drop));
			end
		end
	end

	initial begin
		n_train = 0;
		n_test = 0;
		test_errs = 0;
		stump_ok = 1'b0;
		stump_dim = 0;
		stump_pol = 0;
		stump_thr = 0;
		overflow_pending = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(450);
		test_output_holdoff();
		test_train_overflow();
		// final stretch with no idling on either side
		idle_on = 1'b0;
		test_random(150);
		repeat (50) @(negedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/dst_pkg.sv
design/dst_ctrl.sv
design/dst_datapath.sv
design/decision_stump_trainer.sv
tb/testbench.sv
